FILE: rtl/ceq_pkg.sv
package ceq_pkg;

  localparam int DEPTH_DEF        = 16;
  localparam int PAYLOAD_BITS_DEF = 32;
  localparam int KIND_W           = 4;
  localparam int NUM_KINDS        = 16;
  localparam int SEQ_W            = 32;
  localparam int DROP_W           = 32;
  localparam int CAP_W            = 5;
  localparam int OCC_W            = 5;
  localparam int OP_W             = 2;
  localparam int STATUS_W         = 3;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 16;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [OP_W-1:0] {
    OP_ENQ   = 2'd0,
    OP_CLOSE = 2'd1,
    OP_POP   = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_QUEUED    = 3'd0,
    ST_COALESCED = 3'd1,
    ST_DROPPED   = 3'd2,
    ST_POPPED    = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SUPPRESS = 3'd0,
    CFG_MASK     = 3'd1,
    CFG_KEEP     = 3'd2,
    CFG_CLOSE    = 3'd3,
    CFG_CAPACITY = 3'd4
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_ENQ,
    S_MRG_RD,
    S_MRG_CHK,
    S_FULL,
    S_VIC_RD,
    S_VIC_CHK,
    S_SHIFT,
    S_SH_RD,
    S_SH_WR,
    S_APPEND,
    S_POP_RD,
    S_POP_CHK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic    capture;
    logic    set_close;
    logic    idx_zero;
    logic    idx_top;
    logic    idx_inc;
    logic    idx_dec;
    logic    rd_next;
    logic    wr_merge;
    logic    wr_shift;
    logic    wr_append;
    logic    drop_inc;
    logic    count_dec;
    logic    pop;
    logic    res_load;
    status_t res_status;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic in_fire;
    op_t  op;
    logic close_set;
    logic suppress;
    logic cap_zero;
    logic kind_merge;
    logic count_zero;
    logic rd_merge;
    logic rd_match;
    logic idx_zero;
    logic idx_last;
    logic full;
    logic shift_more;
    logic kind_keep;
    logic out_busy;
  } sts_t;

endpackage

FILE: rtl/ceq_in_if.sv
interface ceq_in_if #(
  parameter int PAYLOAD_BITS = ceq_pkg::PAYLOAD_BITS_DEF
) ();
  logic                        valid;
  logic                        ready;
  logic [ceq_pkg::OP_W-1:0]    op;
  logic [ceq_pkg::KIND_W-1:0]  event_kind;
  logic [PAYLOAD_BITS-1:0]     payload;

  modport source (output valid, output op, output event_kind, output payload, input ready);
  modport sink   (input valid, input op, input event_kind, input payload, output ready);
endinterface

FILE: rtl/ceq_out_if.sv
interface ceq_out_if #(
  parameter int PAYLOAD_BITS = ceq_pkg::PAYLOAD_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic [ceq_pkg::STATUS_W-1:0]  status;
  logic [ceq_pkg::KIND_W-1:0]    out_kind;
  logic [PAYLOAD_BITS-1:0]       out_payload;
  logic [ceq_pkg::SEQ_W-1:0]     out_sequence;
  logic [ceq_pkg::DROP_W-1:0]    drop_total;
  logic [ceq_pkg::OCC_W-1:0]     occupancy;

  modport source (output valid, output status, output out_kind, output out_payload,
                  output out_sequence, output drop_total, output occupancy, input ready);
  modport sink   (input valid, input status, input out_kind, input out_payload,
                  input out_sequence, input drop_total, input occupancy, output ready);
endinterface

FILE: rtl/coalescing_event_queue_top.sv
// Flow: a latched close request or the unused op code is answered at dispatch, a suppressed
// or capacity-zero enqueue at the enqueue check, a pop after a head read and a plain append
// after the full check; an enqueue may first search, discard and shift.
// Throughput: one item at a time; a search step reads and checks a slot and a shift step reads
// and writes one, so backward coalesce, forward victim and shift-down walks set the cost.
// Reset: synchronous, active low; it clears the queue pointers, counters, close latch and
// configuration (capacity returns to 16). Slot contents are not cleared.
module coalescing_event_queue_top #(
  parameter int DEPTH        = ceq_pkg::DEPTH_DEF,
  parameter int PAYLOAD_BITS = ceq_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  ceq_in_if.sink                         in_chan,
  ceq_out_if.source                      out_chan,
  input  logic                           cfg_we,
  input  logic [ceq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ceq_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  // The controller steps through the search, shift and append phases; the datapath
  // holds the slot memory, pointers, counters and the output register.
  ceq_pkg::cmd_t cmd;
  ceq_pkg::sts_t sts;
  logic          in_ready;
  logic          in_fire;

  assign in_chan.ready = in_ready;
  assign in_fire       = in_chan.valid && in_ready;

  ceq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  ceq_dp #(
    .DEPTH        (DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_fire      (in_fire),
    .in_op        (in_chan.op),
    .in_kind      (in_chan.event_kind),
    .in_payload   (in_chan.payload),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .out_valid    (out_chan.valid),
    .out_ready    (out_chan.ready),
    .out_status   (out_chan.status),
    .out_kind     (out_chan.out_kind),
    .out_payload  (out_chan.out_payload),
    .out_sequence (out_chan.out_sequence),
    .out_drop     (out_chan.drop_total),
    .out_occ      (out_chan.occupancy)
  );

endmodule

FILE: rtl/ceq_ctrl.sv
module ceq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  ceq_pkg::sts_t sts,
  output ceq_pkg::cmd_t cmd,
  output logic          in_ready
);

  ceq_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ceq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ceq_pkg::S_IDLE: begin
        if (sts.in_fire) state_nxt = ceq_pkg::S_DISPATCH;
      end
      ceq_pkg::S_DISPATCH: begin
        case (sts.op)
          ceq_pkg::OP_ENQ:   state_nxt = ceq_pkg::S_ENQ;
          ceq_pkg::OP_CLOSE: state_nxt = sts.close_set ? ceq_pkg::S_DONE : ceq_pkg::S_ENQ;
          ceq_pkg::OP_POP:   state_nxt = sts.count_zero ? ceq_pkg::S_DONE : ceq_pkg::S_POP_RD;
          default:           state_nxt = ceq_pkg::S_DONE;
        endcase
      end
      ceq_pkg::S_ENQ: begin
        if (sts.suppress || sts.cap_zero) state_nxt = ceq_pkg::S_DONE;
        else if (sts.kind_merge && !sts.count_zero) state_nxt = ceq_pkg::S_MRG_RD;
        else state_nxt = ceq_pkg::S_FULL;
      end
      ceq_pkg::S_MRG_RD: state_nxt = ceq_pkg::S_MRG_CHK;
      ceq_pkg::S_MRG_CHK: begin
        if (!sts.rd_merge) state_nxt = ceq_pkg::S_FULL;
        else if (sts.rd_match) state_nxt = ceq_pkg::S_DONE;
        else if (sts.idx_zero) state_nxt = ceq_pkg::S_FULL;
        else state_nxt = ceq_pkg::S_MRG_RD;
      end
      ceq_pkg::S_FULL: state_nxt = sts.full ? ceq_pkg::S_VIC_RD : ceq_pkg::S_APPEND;
      ceq_pkg::S_VIC_RD: state_nxt = ceq_pkg::S_VIC_CHK;
      ceq_pkg::S_VIC_CHK: begin
        if (sts.rd_merge) state_nxt = ceq_pkg::S_SHIFT;
        else if (sts.idx_last) state_nxt = sts.kind_keep ? ceq_pkg::S_SHIFT : ceq_pkg::S_DONE;
        else state_nxt = ceq_pkg::S_VIC_RD;
      end
      ceq_pkg::S_SHIFT: state_nxt = sts.shift_more ? ceq_pkg::S_SH_RD : ceq_pkg::S_APPEND;
      ceq_pkg::S_SH_RD: state_nxt = ceq_pkg::S_SH_WR;
      ceq_pkg::S_SH_WR: state_nxt = ceq_pkg::S_SHIFT;
      ceq_pkg::S_APPEND: state_nxt = ceq_pkg::S_DONE;
      ceq_pkg::S_POP_RD: state_nxt = ceq_pkg::S_POP_CHK;
      ceq_pkg::S_POP_CHK: state_nxt = ceq_pkg::S_DONE;
      ceq_pkg::S_DONE: begin
        if (!sts.out_busy) state_nxt = ceq_pkg::S_IDLE;
      end
      default: state_nxt = ceq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.res_status = ceq_pkg::ST_COALESCED;
    in_ready       = 1'b0;
    case (state_r)
      ceq_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = sts.in_fire;
      end
      ceq_pkg::S_DISPATCH: begin
        case (sts.op)
          ceq_pkg::OP_ENQ: ;
          ceq_pkg::OP_CLOSE: begin
            if (sts.close_set) cmd.res_load = 1'b1;
            else cmd.set_close = 1'b1;
          end
          ceq_pkg::OP_POP: begin
            if (sts.count_zero) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = ceq_pkg::ST_EMPTY;
            end else begin
              cmd.idx_zero = 1'b1;
            end
          end
          default: cmd.res_load = 1'b1;
        endcase
      end
      ceq_pkg::S_ENQ: begin
        if (sts.suppress) begin
          cmd.res_load = 1'b1;
        end else if (sts.cap_zero) begin
          cmd.drop_inc   = 1'b1;
          cmd.res_load   = 1'b1;
          cmd.res_status = ceq_pkg::ST_DROPPED;
        end else if (sts.kind_merge && !sts.count_zero) begin
          cmd.idx_top = 1'b1;
        end
      end
      ceq_pkg::S_MRG_CHK: begin
        if (sts.rd_merge && sts.rd_match) begin
          cmd.wr_merge = 1'b1;
          cmd.res_load = 1'b1;
        end else if (sts.rd_merge && !sts.idx_zero) begin
          cmd.idx_dec = 1'b1;
        end
      end
      ceq_pkg::S_FULL: begin
        cmd.idx_zero = sts.full;
      end
      ceq_pkg::S_VIC_CHK: begin
        if (!sts.rd_merge) begin
          if (sts.idx_last) begin
            if (sts.kind_keep) begin
              cmd.idx_zero = 1'b1;
            end else begin
              cmd.drop_inc   = 1'b1;
              cmd.res_load   = 1'b1;
              cmd.res_status = ceq_pkg::ST_DROPPED;
            end
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      ceq_pkg::S_SHIFT: begin
        if (!sts.shift_more) begin
          cmd.count_dec = 1'b1;
          cmd.drop_inc  = 1'b1;
        end
      end
      ceq_pkg::S_SH_RD: cmd.rd_next = 1'b1;
      ceq_pkg::S_SH_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_inc  = 1'b1;
      end
      ceq_pkg::S_APPEND: begin
        cmd.wr_append  = 1'b1;
        cmd.res_load   = 1'b1;
        cmd.res_status = ceq_pkg::ST_QUEUED;
      end
      ceq_pkg::S_POP_CHK: begin
        cmd.pop        = 1'b1;
        cmd.res_load   = 1'b1;
        cmd.res_status = ceq_pkg::ST_POPPED;
      end
      ceq_pkg::S_DONE: cmd.out_load = !sts.out_busy;
      default: ;
    endcase
  end

endmodule

FILE: rtl/ceq_dp.sv
module ceq_dp #(
  parameter int DEPTH        = ceq_pkg::DEPTH_DEF,
  parameter int PAYLOAD_BITS = ceq_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ceq_pkg::cmd_t                    cmd,
  output ceq_pkg::sts_t                    sts,
  input  logic                             in_fire,
  input  logic [ceq_pkg::OP_W-1:0]         in_op,
  input  logic [ceq_pkg::KIND_W-1:0]       in_kind,
  input  logic [PAYLOAD_BITS-1:0]          in_payload,
  input  logic                             cfg_we,
  input  logic [ceq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ceq_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [ceq_pkg::STATUS_W-1:0]     out_status,
  output logic [ceq_pkg::KIND_W-1:0]       out_kind,
  output logic [PAYLOAD_BITS-1:0]          out_payload,
  output logic [ceq_pkg::SEQ_W-1:0]        out_sequence,
  output logic [ceq_pkg::DROP_W-1:0]       out_drop,
  output logic [ceq_pkg::OCC_W-1:0]        out_occ
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > ceq_pkg::CAP_W) ? CW : ceq_pkg::CAP_W;
  localparam int EW   = ceq_pkg::KIND_W + PAYLOAD_BITS + ceq_pkg::SEQ_W;

  // configuration
  logic                            suppress_r;
  logic [ceq_pkg::NUM_KINDS-1:0]   mask_r;
  logic [ceq_pkg::KIND_W-1:0]      keep_r;
  logic [ceq_pkg::KIND_W-1:0]      close_kind_r;
  logic [ceq_pkg::CAP_W-1:0]       cap_r;

  // queue state
  logic [AW-1:0]                   head_r;
  logic [CW-1:0]                   count_r;
  logic [CW-1:0]                   idx_r;
  logic [ceq_pkg::DROP_W-1:0]      drop_r;
  logic [ceq_pkg::SEQ_W-1:0]       seq_r;
  logic                            close_r;

  // current item
  ceq_pkg::op_t                    op_r;
  logic [ceq_pkg::KIND_W-1:0]      kind_r;
  logic [PAYLOAD_BITS-1:0]         data_r;

  // result held until the output register is free
  ceq_pkg::status_t                res_status_r;
  logic [ceq_pkg::KIND_W-1:0]      res_kind_r;
  logic [PAYLOAD_BITS-1:0]         res_pay_r;
  logic [ceq_pkg::SEQ_W-1:0]       res_seq_r;

  logic                            out_valid_r;
  ceq_pkg::status_t                out_status_r;
  logic [ceq_pkg::KIND_W-1:0]      out_kind_r;
  logic [PAYLOAD_BITS-1:0]         out_pay_r;
  logic [ceq_pkg::SEQ_W-1:0]       out_seq_r;
  logic [ceq_pkg::DROP_W-1:0]      out_drop_r;
  logic [ceq_pkg::OCC_W-1:0]       out_occ_r;

  logic [EW-1:0]                   mem [DEPTH];
  logic [EW-1:0]                   rd_r;

  logic [ceq_pkg::KIND_W-1:0]      rd_kind;
  logic [PAYLOAD_BITS-1:0]         rd_pay;
  logic [ceq_pkg::SEQ_W-1:0]       rd_seq;
  logic [CW:0]                     rd_sum, wr_sum;
  logic [CW-1:0]                   rd_log, wr_log;
  logic [AW-1:0]                   rd_addr, wr_addr;
  logic                            wr_en;
  logic [EW-1:0]                   wr_data;
  logic [CMPW-1:0]                 cap_eff;

  assign rd_kind = rd_r[EW-1 -: ceq_pkg::KIND_W];
  assign rd_pay  = rd_r[ceq_pkg::SEQ_W +: PAYLOAD_BITS];
  assign rd_seq  = rd_r[ceq_pkg::SEQ_W-1:0];

  // Logical to physical slot: head plus offset, folded once around the ring.
  always_comb begin
    rd_log  = cmd.rd_next ? (idx_r + CW'(1)) : idx_r;
    wr_log  = cmd.wr_append ? count_r : idx_r;
    rd_sum  = (CW+1)'(head_r) + (CW+1)'(rd_log);
    wr_sum  = (CW+1)'(head_r) + (CW+1)'(wr_log);
    rd_addr = (rd_sum >= (CW+1)'(DEPTH)) ? AW'(rd_sum - (CW+1)'(DEPTH)) : AW'(rd_sum);
    wr_addr = (wr_sum >= (CW+1)'(DEPTH)) ? AW'(wr_sum - (CW+1)'(DEPTH)) : AW'(wr_sum);
    wr_en   = cmd.wr_merge | cmd.wr_shift | cmd.wr_append;
    if (cmd.wr_append) wr_data = {kind_r, data_r, seq_r};
    else if (cmd.wr_merge) wr_data = {rd_kind, data_r, rd_seq};
    else wr_data = rd_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_r <= mem[rd_addr];
  end

  always_comb begin
    cap_eff = (CMPW'(cap_r) > CMPW'(DEPTH)) ? CMPW'(DEPTH) : CMPW'(cap_r);
    sts.in_fire    = in_fire;
    sts.op         = op_r;
    sts.close_set  = close_r;
    sts.suppress   = suppress_r;
    sts.cap_zero   = (cap_r == '0);
    sts.kind_merge = mask_r[kind_r];
    sts.count_zero = (count_r == '0);
    sts.rd_merge   = mask_r[rd_kind];
    sts.rd_match   = (rd_kind == kind_r);
    sts.idx_zero   = (idx_r == '0);
    sts.idx_last   = (idx_r == count_r - CW'(1));
    sts.full       = (CMPW'(count_r) >= cap_eff);
    sts.shift_more = ((CW+1)'(idx_r) + (CW+1)'(1)) < (CW+1)'(count_r);
    sts.kind_keep  = (kind_r == keep_r);
    sts.out_busy   = out_valid_r && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      suppress_r   <= 1'b0;
      mask_r       <= '0;
      keep_r       <= '0;
      close_kind_r <= '0;
      cap_r        <= ceq_pkg::CAP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ceq_pkg::CFG_SUPPRESS: suppress_r   <= cfg_wdata[0];
        ceq_pkg::CFG_MASK:     mask_r       <= cfg_wdata[ceq_pkg::NUM_KINDS-1:0];
        ceq_pkg::CFG_KEEP:     keep_r       <= cfg_wdata[ceq_pkg::KIND_W-1:0];
        ceq_pkg::CFG_CLOSE:    close_kind_r <= cfg_wdata[ceq_pkg::KIND_W-1:0];
        ceq_pkg::CFG_CAPACITY: cap_r        <= cfg_wdata[ceq_pkg::CAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      drop_r      <= '0;
      seq_r       <= '0;
      close_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.set_close) close_r <= 1'b1;
      if (cmd.idx_zero) idx_r <= '0;
      else if (cmd.idx_top) idx_r <= count_r - CW'(1);
      else if (cmd.idx_inc) idx_r <= idx_r + CW'(1);
      else if (cmd.idx_dec) idx_r <= idx_r - CW'(1);
      if (cmd.drop_inc) drop_r <= drop_r + ceq_pkg::DROP_W'(1);
      if (cmd.wr_append) begin
        seq_r   <= seq_r + ceq_pkg::SEQ_W'(1);
        count_r <= count_r + CW'(1);
      end else if (cmd.count_dec || cmd.pop) begin
        count_r <= count_r - CW'(1);
      end
      if (cmd.pop) head_r <= (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= ceq_pkg::op_t'(in_op);
      kind_r <= (ceq_pkg::op_t'(in_op) == ceq_pkg::OP_CLOSE) ? close_kind_r : in_kind;
      data_r <= in_payload;
    end
    if (cmd.res_load) begin
      res_status_r <= cmd.res_status;
      res_kind_r   <= cmd.pop ? rd_kind : '0;
      res_pay_r    <= cmd.pop ? rd_pay : '0;
      res_seq_r    <= cmd.pop ? rd_seq : '0;
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_kind_r   <= res_kind_r;
      out_pay_r    <= res_pay_r;
      out_seq_r    <= res_seq_r;
      out_drop_r   <= drop_r;
      out_occ_r    <= ceq_pkg::OCC_W'(count_r);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_kind     = out_kind_r;
  assign out_payload  = out_pay_r;
  assign out_sequence = out_seq_r;
  assign out_drop     = out_drop_r;
  assign out_occ      = out_occ_r;

endmodule
